FILE: hdl/pgtw_pkg.sv
// ----------------------------------------------------------------------------
// Page table walker package
// Shared types, codes and descriptor constants for the page table block.
// ----------------------------------------------------------------------------
package pgtw_pkg;

  localparam int unsigned TablePagesDef = 64;
  localparam int unsigned EntryIdxW     = 9;

  localparam logic [63:0] D_VALID  = 64'h1;
  localparam logic [63:0] D_TABLE  = 64'h2;
  localparam logic [63:0] D_ACCESS = 64'h400;

  typedef enum logic [1:0] {
    KIND_PAGE  = 2'd0,
    KIND_2M    = 2'd1,
    KIND_1G    = 2'd2,
    KIND_XLATE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_EXHAUSTED  = 3'd2,
    ST_CONFLICT   = 3'd3,
    ST_UNMAPPED   = 3'd4
  } status_t;

  typedef enum logic {
    CFG_POOL_BASE  = 1'b0,
    CFG_POOL_PAGES = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    kind_t       kind;
    logic [47:0] virt_addr;
    logic [47:0] target_address;
    logic [63:0] attr_bits;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [47:0] translated_address;
  } out_beat_t;

endpackage

FILE: hdl/pgtw_ram.sv
// ----------------------------------------------------------------------------
// Page table walker RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pgtw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/four_level_page_table_map_and_walk.sv
// An early error goes from the input beat through S_START to S_DONE; a full four-level
// walk passes S_RD and S_EVAL once per table level, paced by the registered read of the table RAM.
// One request is handled at a time; the next beat is accepted the cycle after the result
// is registered, and a stall on the result holds the block in S_DONE until it is taken.
// Reset is synchronous and active low; it starts a clearing pass over all TABLE_PAGES*512
// entries (32768 by default) of the table RAM, during which no request is accepted.
// ----------------------------------------------------------------------------
// Four-level page table map and walk
// Builds and walks 4 KB granule translation tables in an on-chip RAM.
// ----------------------------------------------------------------------------
module four_level_page_table_map_and_walk import pgtw_pkg::*; #(
  parameter int unsigned TABLE_PAGES = TablePagesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int unsigned PG_W  = $clog2(TABLE_PAGES);
  localparam int unsigned DEPTH = TABLE_PAGES * (2 ** EntryIdxW);
  localparam int unsigned AW    = PG_W + EntryIdxW;
  localparam int unsigned CW    = (PG_W + 1 > 7) ? PG_W + 1 : 7;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_START, S_RD, S_EVAL, S_DONE
  } state_t;

  state_t          state_r;
  in_beat_t        req_r;
  logic [1:0]      lvl_r;
  logic            root_present_r;
  logic [PG_W-1:0] root_page_r;
  logic [PG_W:0]   next_free_r;
  logic [35:0]     pool_base_r;
  logic [6:0]      pool_pages_r;
  logic [AW-1:0]   addr_r;
  logic            out_valid_r;
  out_beat_t       out_r;
  status_t         st_r;
  logic [47:0]     pa_r;

  logic [63:0]     rd_data;
  logic            we_c;
  logic [63:0]     wdata_c;
  logic            can_alloc;
  logic [PG_W-1:0] new_pg;
  logic [35:0]     alloc_addr;
  logic [35:0]     off;
  logic            in_store;
  logic [1:0]      levels;
  logic            is_map;
  logic [47:0]     pa_masked;
  logic [63:0]     leaf_desc;
  logic [1:0]      lvl_nxt;

  function automatic logic [EntryIdxW-1:0] idx_of(input logic [47:0] va, input logic [1:0] lvl);
    logic [EntryIdxW-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  pgtw_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we_c),
    .waddr (addr_r),
    .wdata (wdata_c),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  assign can_alloc  = (CW'(next_free_r) < CW'(pool_pages_r)) &&
                      (CW'(next_free_r) < CW'(TABLE_PAGES));
  assign new_pg     = next_free_r[PG_W-1:0];
  assign alloc_addr = pool_base_r + 36'(new_pg);
  assign off        = rd_data[47:12] - pool_base_r;
  assign in_store   = off < 36'(TABLE_PAGES);
  assign levels     = 2'd3 - 2'(req_r.kind);
  assign is_map     = req_r.kind != KIND_XLATE;
  assign lvl_nxt    = lvl_r + 2'd1;

  always_comb begin
    case (req_r.kind)
      KIND_PAGE: pa_masked = {req_r.target_address[47:12], 12'h0};
      KIND_2M:   pa_masked = {req_r.target_address[47:21], 21'h0};
      default:   pa_masked = {req_r.target_address[47:30], 30'h0};
    endcase
    leaf_desc = D_VALID | D_ACCESS | req_r.attr_bits | {16'h0, pa_masked};
    if (req_r.kind == KIND_PAGE) begin
      leaf_desc = leaf_desc | D_TABLE;
    end
  end

  always_comb begin
    we_c    = 1'b0;
    wdata_c = '0;
    if (state_r == S_CLEAR) begin
      we_c = 1'b1;
    end else if (state_r == S_EVAL && is_map) begin
      if (lvl_r != levels) begin
        we_c    = !rd_data[0] && can_alloc;
        wdata_c = D_VALID | D_TABLE | {16'h0, alloc_addr, 12'h0};
      end else begin
        we_c    = !(req_r.kind != KIND_PAGE && rd_data[0]);
        wdata_c = leaf_desc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      addr_r         <= '0;
      root_present_r <= 1'b0;
      root_page_r    <= '0;
      next_free_r    <= '0;
      pool_base_r    <= '0;
      pool_pages_r   <= 7'd64;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_POOL_BASE) begin
          pool_base_r <= cfg_data[47:12];
        end else begin
          pool_pages_r <= cfg_data[6:0];
        end
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          addr_r <= addr_r + AW'(1);
          if (addr_r == AW'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= S_START;
          end
        end
        S_START: begin
          pa_r    <= '0;
          lvl_r   <= 2'd0;
          state_r <= S_RD;
          addr_r  <= {root_page_r, idx_of(req_r.virt_addr, 2'd0)};
          if (req_r.kind == KIND_XLATE) begin
            if (!root_present_r) begin
              st_r    <= ST_UNMAPPED;
              state_r <= S_DONE;
            end
          end else if ((req_r.kind == KIND_2M &&
                        (req_r.virt_addr[20:0] != '0 ||
                         req_r.target_address[20:0] != '0)) ||
                       (req_r.kind == KIND_1G &&
                        (req_r.virt_addr[29:0] != '0 ||
                         req_r.target_address[29:0] != '0))) begin
            st_r    <= ST_MISALIGNED;
            state_r <= S_DONE;
          end else if (!root_present_r) begin
            if (can_alloc) begin
              root_page_r    <= new_pg;
              root_present_r <= 1'b1;
              next_free_r    <= next_free_r + 1'b1;
              addr_r         <= {new_pg, idx_of(req_r.virt_addr, 2'd0)};
            end else begin
              st_r    <= ST_EXHAUSTED;
              state_r <= S_DONE;
            end
          end
        end
        S_RD: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          state_r <= S_DONE;
          if (is_map) begin
            if (lvl_r == levels) begin
              st_r <= (req_r.kind != KIND_PAGE && rd_data[0]) ? ST_CONFLICT : ST_OK;
            end else if (!rd_data[0]) begin
              if (can_alloc) begin
                next_free_r <= next_free_r + 1'b1;
                addr_r      <= {new_pg, idx_of(req_r.virt_addr, lvl_nxt)};
                lvl_r       <= lvl_nxt;
                state_r     <= S_RD;
              end else begin
                st_r <= ST_EXHAUSTED;
              end
            end else if (!rd_data[1] || !in_store) begin
              st_r <= ST_CONFLICT;
            end else begin
              addr_r  <= {off[PG_W-1:0], idx_of(req_r.virt_addr, lvl_nxt)};
              lvl_r   <= lvl_nxt;
              state_r <= S_RD;
            end
          end else begin
            if (!rd_data[0]) begin
              st_r <= ST_UNMAPPED;
            end else if (lvl_r == 2'd3) begin
              st_r <= ST_OK;
              pa_r <= {rd_data[47:12], req_r.virt_addr[11:0]};
            end else if (!rd_data[1]) begin
              if (lvl_r == 2'd1) begin
                st_r <= ST_OK;
                pa_r <= {rd_data[47:30], req_r.virt_addr[29:0]};
              end else if (lvl_r == 2'd2) begin
                st_r <= ST_OK;
                pa_r <= {rd_data[47:21], req_r.virt_addr[20:0]};
              end else begin
                st_r <= ST_UNMAPPED;
              end
            end else if (in_store) begin
              addr_r  <= {off[PG_W-1:0], idx_of(req_r.virt_addr, lvl_nxt)};
              lvl_r   <= lvl_nxt;
              state_r <= S_RD;
            end else begin
              st_r <= ST_UNMAPPED;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r.status             <= st_r;
            out_r.translated_address <= (st_r == ST_OK) ? pa_r : '0;
            out_valid_r              <= 1'b1;
            state_r                  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hdl/pgtw_checker.sv
// ----------------------------------------------------------------------------
// Page table walker checker
// Port-level checks on the page table block, bound to the top level.
// ----------------------------------------------------------------------------
module pgtw_checker import pgtw_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result beat changed while stalled.");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.translated_address == '0)
    else $error("Failed request carries a nonzero address.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Request taken while another is in progress.");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("Request taken before the table clear finished.");

endmodule

bind four_level_page_table_map_and_walk pgtw_checker u_pgtw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
